[sv/arhp_pkg.sv]
// Shared types and constants for the ar archive header parser.
// Used by every module of the block and by its port checker.
package arhp_pkg;

	// Width of the running archive offset counter.
	localparam int unsigned OFFSET_BITS = 40;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned NUM_W    = 34;
	localparam int unsigned DOFS_W   = 40;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned SLEN_W   = 5;
	localparam int unsigned TDATA_W  = 112;
	localparam int unsigned TUSER_W  = 4;

	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

	// Header layout: name field, size field and terminator positions.
	localparam logic [POS_W-1:0] POS_NAME_END   = 6'd16;
	localparam logic [POS_W-1:0] POS_SIZE_START = 6'd48;
	localparam logic [POS_W-1:0] POS_TERM_A     = 6'd58;
	localparam logic [POS_W-1:0] POS_TERM_B     = 6'd59;
	localparam logic [POS_W-1:0] POS_MAGIC_LAST = 6'd7;
	localparam logic [SLEN_W-1:0] SLEN_NONE     = 5'd16;

	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_GRAVE = 8'h60;

	typedef enum logic [2:0] {
		KIND_REGULAR   = 3'd0,
		KIND_SYMTAB    = 3'd1,
		KIND_NAMETAB   = 3'd2,
		KIND_BAD_MAGIC = 3'd3,
		KIND_BAD_TERM  = 3'd4,
		KIND_TRUNCATED = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t              entry_kind;
		logic               long_name;
		logic [NUM_W-1:0]   name_value;
		logic               name_ok;
		logic [DOFS_W-1:0]  data_offset;
		logic [NUM_W-1:0]   data_size;
	} result_t;

	// The eight bytes of the archive signature "!<arch>\n".
	function automatic logic [BYTE_W-1:0] magic_byte(input logic [2:0] idx);
		logic [BYTE_W-1:0] r;
		unique case (idx)
			3'd0: r = 8'h21;
			3'd1: r = 8'h3c;
			3'd2: r = 8'h61;
			3'd3: r = 8'h72;
			3'd4: r = 8'h63;
			3'd5: r = 8'h68;
			3'd6: r = 8'h3e;
			default: r = 8'h0a;
		endcase
		return r;
	endfunction

endpackage

[sv/ar_archive_header_parser.sv]
// Top level of the ar archive header parser: stream ports and result register.
// Depends on arhp_pkg and arhp_parser.
//
// The archive image enters on the slave stream one byte per transaction, with
// s_tlast on its final byte. The block checks the signature, parses every
// 60-byte member header and skips member data and newline padding.
// For each complete header, and for a bad signature, a bad terminator or a
// truncated archive, one result transaction leaves on the master stream;
// all other bytes produce nothing.
// The result is registered and appears in m_tvalid in the cycle after the byte that
// caused it is accepted.
// Throughput: one byte per cycle; each byte passes through a single
// combinational update of the parser registers feeding the result register.
// When the receiver stalls, s_tready stays high while the result register is
// empty or is being emptied in the same cycle; with a result held and
// m_tready low, input waits.
// Reset clears the parser to the start of an archive and empties the result
// register. The byte with s_tlast re-arms the parser in the same way.
module ar_archive_header_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [arhp_pkg::BYTE_W-1:0]  s_tdata,  // [7:0] archive_byte
	input  logic                         s_tlast,  // last_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [33:0] name_value, [34] name_ok, [74:35] data_offset, [108:75] data_size,
	// [111:109] zero
	output logic [arhp_pkg::TDATA_W-1:0] m_tdata,
	output logic [arhp_pkg::TUSER_W-1:0] m_tuser   // [2:0] entry_kind, [3] long_name
);
	import arhp_pkg::*;

	logic    accept;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	arhp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.data_byte (s_tdata),
		.last      (s_tlast),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.data_size, out_q.data_offset, out_q.name_ok,
		out_q.name_value};
	assign m_tuser  = {out_q.long_name, out_q.entry_kind};

endmodule

[sv/arhp_dec_step.sv]
// One digit step of a saturating decimal field parser.
// Depends on arhp_pkg for widths and character codes.
module arhp_dec_step (
	input  logic [arhp_pkg::NUM_W-1:0]  acc,
	input  logic [1:0]                  flags,
	input  logic [arhp_pkg::BYTE_W-1:0] data_byte,
	output logic [arhp_pkg::NUM_W-1:0]  acc_next,
	output logic [1:0]                  flags_next
);
	import arhp_pkg::*;

	logic              is_digit;
	logic [NUM_W-1:0]  base;
	logic [NUM_W+3:0]  prod;

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign base     = flags[0] ? acc : '0;
	// Times ten as a sum of two shifts, plus the new digit.
	assign prod = {base, 3'b000} + {2'b00, base, 1'b0}
		+ (NUM_W+4)'(data_byte - CH_ZERO);

	// Flag bit 0: a digit has been seen; bit 1: the number has ended.
	always_comb begin
		acc_next   = acc;
		flags_next = flags;
		if (is_digit) begin
			if (!flags[1]) begin
				acc_next   = (prod > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : prod[NUM_W-1:0];
				flags_next = flags | 2'b01;
			end
		end else if (flags[0]) begin
			flags_next = flags | 2'b10;
		end
	end

endmodule

[sv/arhp_parser.sv]
// Parser state and per-byte next-state logic for the ar archive stream.
// Depends on arhp_pkg and two arhp_dec_step instances.
module arhp_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [arhp_pkg::BYTE_W-1:0] data_byte,
	input  logic                        last,
	output logic                        res_valid,
	output arhp_pkg::result_t           res
);
	import arhp_pkg::*;

	typedef enum logic [4:0] {
		PH_MAGIC  = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_PAD    = 5'b01000,
		PH_HALT   = 5'b10000
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [POS_W-1:0]       pos_q, pos_n;
	logic [NUM_W-1:0]       rem_q, rem_n;
	logic [NUM_W-1:0]       size_acc_q, size_acc_n;
	logic [1:0]             size_flg_q, size_flg_n;
	logic [NUM_W-1:0]       idx_acc_q, idx_acc_n;
	logic [1:0]             idx_flg_q, idx_flg_n;
	logic [SLEN_W-1:0]      slen_q, slen_n;
	logic [15:0]            prefix_q, prefix_n;
	logic                   term_ok_q, term_ok_n;
	logic [OFFSET_BITS-1:0] boff_q, boff_n;
	logic                   tbl_seen_q, tbl_seen_n;
	logic [NUM_W-1:0]       tbl_size_q, tbl_size_n;

	// Header fields as seen by this byte: fresh when a header opens after padding.
	logic                   hdr_start;
	logic [POS_W-1:0]       pos_e;
	logic [NUM_W-1:0]       size_acc_e, idx_acc_e;
	logic [1:0]             size_flg_e, idx_flg_e;
	logic [SLEN_W-1:0]      slen_e;
	logic [15:0]            prefix_e;
	logic                   term_ok_e;
	logic [NUM_W-1:0]       size_acc_d, idx_acc_d;
	logic [1:0]             size_flg_d, idx_flg_d;
	logic [NUM_W-1:0]       rem_dec;
	logic [OFFSET_BITS-1:0] boff_inc;
	logic                   do_header;

	assign hdr_start  = (phase_q == PH_PAD) && (data_byte != CH_LF);
	assign pos_e      = hdr_start ? '0 : pos_q;
	assign size_acc_e = hdr_start ? '0 : size_acc_q;
	assign size_flg_e = hdr_start ? '0 : size_flg_q;
	assign idx_acc_e  = hdr_start ? '0 : idx_acc_q;
	assign idx_flg_e  = hdr_start ? '0 : idx_flg_q;
	assign slen_e     = hdr_start ? SLEN_NONE : slen_q;
	assign prefix_e   = hdr_start ? '0 : prefix_q;
	assign term_ok_e  = hdr_start ? 1'b0 : term_ok_q;
	assign do_header  = (phase_q == PH_HEADER) || hdr_start;
	assign boff_inc   = boff_q + OFFSET_BITS'(1);
	assign rem_dec    = (rem_q != '0) ? rem_q - NUM_W'(1) : rem_q;

	arhp_dec_step u_size_dec (
		.acc        (size_acc_e),
		.flags      (size_flg_e),
		.data_byte  (data_byte),
		.acc_next   (size_acc_d),
		.flags_next (size_flg_d)
	);

	arhp_dec_step u_idx_dec (
		.acc        (idx_acc_e),
		.flags      (idx_flg_e),
		.data_byte  (data_byte),
		.acc_next   (idx_acc_d),
		.flags_next (idx_flg_d)
	);

	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		rem_n      = rem_q;
		size_acc_n = size_acc_q;
		size_flg_n = size_flg_q;
		idx_acc_n  = idx_acc_q;
		idx_flg_n  = idx_flg_q;
		slen_n     = slen_q;
		prefix_n   = prefix_q;
		term_ok_n  = term_ok_q;
		tbl_seen_n = tbl_seen_q;
		tbl_size_n = tbl_size_q;
		boff_n     = boff_inc;
		res_valid  = 1'b0;
		res        = '0;

		if (do_header) begin
			phase_n    = PH_HEADER;
			pos_n      = pos_e;
			size_acc_n = size_acc_e;
			size_flg_n = size_flg_e;
			idx_acc_n  = idx_acc_e;
			idx_flg_n  = idx_flg_e;
			slen_n     = slen_e;
			prefix_n   = prefix_e;
			term_ok_n  = term_ok_e;
			if (pos_e < POS_NAME_END) begin
				if (pos_e == 6'd0) begin
					prefix_n[7:0] = data_byte;
				end
				if (pos_e == 6'd1) begin
					prefix_n[15:8] = data_byte;
				end
				if (data_byte == CH_SLASH && slen_e == SLEN_NONE) begin
					slen_n = pos_e[SLEN_W-1:0];
				end
				if (pos_e != 6'd0) begin
					idx_acc_n = idx_acc_d;
					idx_flg_n = idx_flg_d;
				end
			end else if (pos_e >= POS_SIZE_START && pos_e < POS_TERM_A) begin
				size_acc_n = size_acc_d;
				size_flg_n = size_flg_d;
			end else if (pos_e == POS_TERM_A) begin
				term_ok_n = (data_byte == CH_GRAVE);
			end

			if (pos_e < POS_TERM_B) begin
				pos_n = pos_e + POS_W'(1);
				if (last) begin
					res_valid      = 1'b1;
					res.entry_kind = KIND_TRUNCATED;
				end
			end else if (!(term_ok_e && data_byte == CH_LF)) begin
				phase_n        = PH_HALT;
				res_valid      = 1'b1;
				res.entry_kind = KIND_BAD_TERM;
			end else if (last && size_acc_e != '0) begin
				res_valid      = 1'b1;
				res.entry_kind = KIND_TRUNCATED;
			end else begin
				res_valid       = 1'b1;
				res.data_offset = DOFS_W'(boff_inc);
				res.data_size   = size_acc_e;
				if (prefix_e[7:0] == CH_SLASH && prefix_e[15:8] == CH_SPACE) begin
					res.entry_kind = KIND_SYMTAB;
				end else if (prefix_e[7:0] == CH_SLASH && prefix_e[15:8] == CH_SLASH) begin
					res.entry_kind = KIND_NAMETAB;
					// Only the first extended-name table sets the offset limit.
					if (!tbl_seen_q) begin
						tbl_seen_n = 1'b1;
						tbl_size_n = size_acc_e;
					end
				end else if (prefix_e[7:0] == CH_SLASH) begin
					res.entry_kind = KIND_REGULAR;
					if (idx_flg_e[0]) begin
						res.long_name  = 1'b1;
						res.name_value = idx_acc_e;
						res.name_ok    = tbl_seen_q && (idx_acc_e < tbl_size_q);
					end
				end else begin
					res.entry_kind = KIND_REGULAR;
					res.name_value = NUM_W'(slen_e);
					res.name_ok    = 1'b1;
				end
				rem_n   = size_acc_e;
				phase_n = (size_acc_e != '0) ? PH_DATA : PH_PAD;
			end
		end else begin
			unique case (phase_q)
				PH_MAGIC: begin
					if (data_byte != magic_byte(pos_q[2:0])) begin
						phase_n        = PH_HALT;
						res_valid      = 1'b1;
						res.entry_kind = KIND_BAD_MAGIC;
					end else if (pos_q >= POS_MAGIC_LAST) begin
						phase_n    = PH_HEADER;
						pos_n      = '0;
						size_acc_n = '0;
						size_flg_n = '0;
						idx_acc_n  = '0;
						idx_flg_n  = '0;
						slen_n     = SLEN_NONE;
						prefix_n   = '0;
						term_ok_n  = 1'b0;
					end else begin
						pos_n = pos_q + POS_W'(1);
						if (last) begin
							res_valid      = 1'b1;
							res.entry_kind = KIND_TRUNCATED;
						end
					end
				end
				PH_DATA: begin
					if (last && rem_q > NUM_W'(1)) begin
						res_valid      = 1'b1;
						res.entry_kind = KIND_TRUNCATED;
					end
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						phase_n = PH_PAD;
					end
				end
				default: begin
					// Padding newlines and the halted state consume bytes silently.
				end
			endcase
		end

		// The last byte always returns the parser to its reset state.
		if (last) begin
			phase_n    = PH_MAGIC;
			pos_n      = '0;
			rem_n      = '0;
			size_acc_n = '0;
			size_flg_n = '0;
			idx_acc_n  = '0;
			idx_flg_n  = '0;
			slen_n     = SLEN_NONE;
			prefix_n   = '0;
			term_ok_n  = 1'b0;
			boff_n     = '0;
			tbl_seen_n = 1'b0;
			tbl_size_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MAGIC;
			pos_q      <= '0;
			rem_q      <= '0;
			size_acc_q <= '0;
			size_flg_q <= '0;
			idx_acc_q  <= '0;
			idx_flg_q  <= '0;
			slen_q     <= SLEN_NONE;
			prefix_q   <= '0;
			term_ok_q  <= 1'b0;
			boff_q     <= '0;
			tbl_seen_q <= 1'b0;
			tbl_size_q <= '0;
		end else if (en) begin
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			rem_q      <= rem_n;
			size_acc_q <= size_acc_n;
			size_flg_q <= size_flg_n;
			idx_acc_q  <= idx_acc_n;
			idx_flg_q  <= idx_flg_n;
			slen_q     <= slen_n;
			prefix_q   <= prefix_n;
			term_ok_q  <= term_ok_n;
			boff_q     <= boff_n;
			tbl_seen_q <= tbl_seen_n;
			tbl_size_q <= tbl_size_n;
		end
	end

endmodule

[sv/arhp_checker.sv]
// Port-level checks for the ar archive header parser, bound to its top level.
// Depends on arhp_pkg for the result kind codes and port widths.
module arhp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [arhp_pkg::TDATA_W-1:0] m_tdata,
	input logic [arhp_pkg::TUSER_W-1:0] m_tuser
);
	import arhp_pkg::*;

	// A held result must not change while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// With no result pending the block must take input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[2:0] <= KIND_TRUNCATED)
		else $error("entry kind out of range");

	// Error results carry no other information.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:0] == KIND_BAD_MAGIC || m_tuser[2:0] == KIND_BAD_TERM
			|| m_tuser[2:0] == KIND_TRUNCATED) |-> m_tdata == '0 && !m_tuser[3])
		else $error("error transaction carries payload");

	a_long_regular: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tuser[2:0] == KIND_REGULAR)
		else $error("long name on a special member");

endmodule

bind ar_archive_header_parser arhp_checker u_arhp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[tb/tb_top.sv]
// Self-checking testbench for ar_archive_header_parser: streams ar archive images in
// byte by byte and checks every result against a behavioural predictor.
// Depends on arhp_pkg and the ar_archive_header_parser RTL only.
`timescale 1ns / 1ps

import arhp_pkg::*;

typedef enum logic [2:0] {
	ST_MAGIC,
	ST_HEADER,
	ST_DATA,
	ST_PAD,
	ST_HALT
} parse_phase_t;

localparam logic [63:0] AR_SIGNATURE = "!<arch>\n";

// Tracks the parser state byte by byte and holds the results still owed.
class arch_scoreboard;
	result_t awaited_q[$];
	int unsigned errors;

	parse_phase_t phase;
	logic [POS_W-1:0] field_pos;
	logic [NUM_W-1:0] data_left;
	logic [NUM_W-1:0] size_acc;
	logic [1:0] size_flags;
	logic [NUM_W-1:0] name_idx;
	logic [1:0] idx_flags;
	logic [SLEN_W-1:0] slash_pos;
	logic [15:0] name_head;
	logic grave_seen;
	logic [OFFSET_BITS-1:0] arch_offset;
	logic table_seen;
	logic [NUM_W-1:0] table_size;

	function new();
		errors = 0;
		rearm();
	endfunction

	function void open_member();
		phase = ST_HEADER;
		field_pos = '0;
		size_acc = '0;
		size_flags = '0;
		name_idx = '0;
		idx_flags = '0;
		slash_pos = SLEN_NONE;
		name_head = '0;
		grave_seen = 1'b0;
	endfunction

	function void rearm();
		open_member();
		phase = ST_MAGIC;
		data_left = '0;
		arch_offset = '0;
		table_seen = 1'b0;
		table_size = '0;
	endfunction

	// flags[0]: a digit has been seen, flags[1]: the number has ended.
	function void add_digit(inout logic [NUM_W-1:0] acc, inout logic [1:0] flags,
			input logic [7:0] b);
		logic [NUM_W+3:0] v;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			if (!flags[1]) begin
				v = (NUM_W+4)'(flags[0] ? acc : '0) * (NUM_W+4)'(10) + (NUM_W+4)'(b - CH_ZERO);
				acc = (v > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : v[NUM_W-1:0];
				flags[0] = 1'b1;
			end
		end else if (flags[0]) begin
			flags[1] = 1'b1;
		end
	endfunction

	function void expect_result(kind_t kind, logic ln, logic [NUM_W-1:0] val, logic ok,
			logic [DOFS_W-1:0] off, logic [NUM_W-1:0] sz);
		result_t r;
		r.entry_kind = kind;
		r.long_name = ln;
		r.name_value = val;
		r.name_ok = ok;
		r.data_offset = off;
		r.data_size = sz;
		awaited_q.push_back(r);
	endfunction

	function void header_byte(logic [7:0] b, logic last);
		logic [POS_W-1:0] pos;
		logic [DOFS_W-1:0] off;
		logic [7:0] c0;
		logic [7:0] c1;
		pos = field_pos;
		if (pos < POS_NAME_END) begin
			if (pos == 0) name_head[7:0] = b;
			if (pos == 1) name_head[15:8] = b;
			if (b == CH_SLASH && slash_pos == SLEN_NONE) slash_pos = pos[SLEN_W-1:0];
			if (pos >= 1) add_digit(name_idx, idx_flags, b);
		end else if (pos >= POS_SIZE_START && pos < POS_TERM_A) begin
			add_digit(size_acc, size_flags, b);
		end else if (pos == POS_TERM_A) begin
			grave_seen = (b == CH_GRAVE);
		end
		if (pos < POS_TERM_B) begin
			field_pos = pos + 1'b1;
			if (last) expect_result(KIND_TRUNCATED, 0, 0, 0, 0, 0);
			return;
		end
		if (!(grave_seen && b == CH_LF)) begin
			phase = ST_HALT;
			expect_result(KIND_BAD_TERM, 0, 0, 0, 0, 0);
			return;
		end
		if (last && size_acc != 0) begin
			expect_result(KIND_TRUNCATED, 0, 0, 0, 0, 0);
			return;
		end
		off = DOFS_W'(arch_offset + 1'b1);
		c0 = name_head[7:0];
		c1 = name_head[15:8];
		if (c0 == CH_SLASH && c1 == CH_SPACE) begin
			expect_result(KIND_SYMTAB, 0, 0, 0, off, size_acc);
		end else if (c0 == CH_SLASH && c1 == CH_SLASH) begin
			// Only the first extended-name table sets the bound for long names.
			if (!table_seen) begin
				table_seen = 1'b1;
				table_size = size_acc;
			end
			expect_result(KIND_NAMETAB, 0, 0, 0, off, size_acc);
		end else if (c0 == CH_SLASH) begin
			if (idx_flags[0])
				expect_result(KIND_REGULAR, 1, name_idx, table_seen && name_idx < table_size,
					off, size_acc);
			else
				expect_result(KIND_REGULAR, 0, 0, 0, off, size_acc);
		end else begin
			expect_result(KIND_REGULAR, 0, NUM_W'(slash_pos), 1, off, size_acc);
		end
		data_left = size_acc;
		phase = (size_acc != 0) ? ST_DATA : ST_PAD;
	endfunction

	function void note_byte(logic [7:0] b, logic last);
		int k;
		k = field_pos[2:0];
		case (phase)
			ST_MAGIC: begin
				if (b != AR_SIGNATURE[63-8*k -: 8]) begin
					phase = ST_HALT;
					expect_result(KIND_BAD_MAGIC, 0, 0, 0, 0, 0);
				end else if (field_pos >= POS_MAGIC_LAST) begin
					open_member();
				end else begin
					field_pos = field_pos + 1'b1;
					if (last) expect_result(KIND_TRUNCATED, 0, 0, 0, 0, 0);
				end
			end
			ST_HEADER: header_byte(b, last);
			ST_DATA: begin
				if (last && data_left > 1) expect_result(KIND_TRUNCATED, 0, 0, 0, 0, 0);
				if (data_left > 0) data_left = data_left - 1'b1;
				if (data_left == 0) phase = ST_PAD;
			end
			ST_PAD: begin
				if (b != CH_LF) begin
					open_member();
					header_byte(b, last);
				end
			end
			default: ;
		endcase
		arch_offset = arch_offset + 1'b1;
		if (last) rearm();
	endfunction

	function void compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (awaited_q.size() == 0) begin
			errors++;
			$display("%0t: result expected none, actual kind %0d size %0d", $time,
				got.entry_kind, got.data_size);
			return;
		end
		want = awaited_q.pop_front();
		compare_field("entry_kind", want.entry_kind, got.entry_kind);
		compare_field("long_name", want.long_name, got.long_name);
		compare_field("name_value", want.name_value, got.name_value);
		compare_field("name_ok", want.name_ok, got.name_ok);
		compare_field("data_offset", want.data_offset, got.data_offset);
		compare_field("data_size", want.data_size, got.data_size);
	endfunction

	function int pending();
		return awaited_q.size();
	endfunction
endclass

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned MIN_BYTES = 1600;

	typedef enum {NM_SYMTAB, NM_NAMETAB, NM_LONG, NM_SHORT, NM_PLAIN, NM_SLASH_WORD,
		NM_RANDOM} name_style_t;
	typedef enum {SZ_PLAIN, SZ_LEADING, SZ_JUNK, SZ_EMPTY} size_form_t;
	typedef enum {TERM_OK, TERM_BAD_A, TERM_BAD_B} term_fault_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0] m_tuser;

	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	logic [BYTE_W-1:0] in_byte;
	logic in_last;
	logic [TDATA_W-1:0] out_data;
	logic [TUSER_W-1:0] out_user;

	arch_scoreboard sb = new();
	logic [7:0] archive_img[$];
	int unsigned sent_bytes = 0;
	int unsigned cycle_count = 0;
	bit quiet = 1'b0;

	ar_archive_header_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ar_archive_header_parser verification failed");
			$finish;
		end
	end

	// Signals are stable mid-cycle, so the transactions of the coming edge are decided here.
	always @(negedge clk) begin
		in_fire = arst_n && s_tvalid && s_tready;
		out_fire = arst_n && m_tvalid && m_tready;
		in_byte = s_tdata;
		in_last = s_tlast;
		out_data = m_tdata;
		out_user = m_tuser;
	end

	always @(posedge clk) begin : monitor
		result_t got;
		if (in_fire) sb.note_byte(in_byte, in_last);
		if (out_fire) begin
			got.entry_kind = kind_t'(out_user[2:0]);
			got.long_name = out_user[3];
			got.name_value = out_data[33:0];
			got.name_ok = out_data[34];
			got.data_offset = out_data[74:35];
			got.data_size = out_data[108:75];
			sb.check_result(got);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : sink
		int unsigned stall;
		wait (arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!in_fire);
		sent_bytes++;
	endtask

	task automatic send_image();
		int i;
		for (i = 0; i < archive_img.size(); i++)
			send_byte(archive_img[i], i == archive_img.size() - 1);
	endtask

	// Hold the input off until every owed result has left the block.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'h61 + 8'($urandom_range(0, 25));
		return c;
	endfunction

	function automatic logic [7:0] rand_non_digit();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c >= CH_ZERO && c <= CH_NINE) c = CH_SPACE;
		return c;
	endfunction

	function automatic void put_bytes(int unsigned n);
		repeat (n) archive_img.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_pad(int unsigned n);
		repeat (n) archive_img.push_back(CH_LF);
	endfunction

	function automatic void put_magic(int bad_pos);
		int i;
		logic [7:0] b;
		for (i = 0; i < 8; i++) begin
			b = AR_SIGNATURE[63-8*i -: 8];
			if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
			archive_img.push_back(b);
		end
	endfunction

	function automatic void put_name(name_style_t style, string digits);
		logic [7:0] f[0:15];
		int n;
		int i;
		for (i = 0; i < 16; i++) f[i] = CH_SPACE;
		case (style)
			NM_SYMTAB: f[0] = CH_SLASH;
			NM_NAMETAB: begin
				f[0] = CH_SLASH;
				f[1] = CH_SLASH;
			end
			NM_LONG: begin
				f[0] = CH_SLASH;
				for (i = 0; i < digits.len() && i < 15; i++) f[i+1] = digits[i];
			end
			NM_SHORT: begin
				n = $urandom_range(1, 15);
				for (i = 0; i < n; i++) f[i] = rand_letter();
				f[n] = CH_SLASH;
			end
			NM_PLAIN: for (i = 0; i < 16; i++) f[i] = rand_letter();
			NM_SLASH_WORD: begin
				n = $urandom_range(1, 15);
				f[0] = CH_SLASH;
				for (i = 1; i <= n; i++) f[i] = rand_letter();
			end
			default: for (i = 0; i < 16; i++) f[i] = 8'($urandom_range(0, 255));
		endcase
		for (i = 0; i < 16; i++) archive_img.push_back(f[i]);
	endfunction

	// Writes the ten-byte size field and returns the value the parser should read from it.
	function automatic logic [NUM_W-1:0] put_size(logic [NUM_W-1:0] value, size_form_t form);
		string s;
		int lead;
		int i;
		logic [7:0] c;
		s = $sformatf("%0d", value);
		lead = 0;
		if (form == SZ_LEADING && s.len() < 10) lead = $urandom_range(1, 10 - s.len());
		for (i = 0; i < 10; i++) begin
			if (form == SZ_EMPTY) c = rand_non_digit();
			else if (i < lead) c = CH_SPACE;
			else if (i < lead + s.len()) c = s[i-lead];
			else if (form == SZ_JUNK && i == lead + s.len()) c = rand_non_digit();
			else if (form == SZ_JUNK) c = 8'($urandom_range(0, 255));
			else c = CH_SPACE;
			archive_img.push_back(c);
		end
		return (form == SZ_EMPTY) ? '0 : value;
	endfunction

	function automatic logic [NUM_W-1:0] put_header(name_style_t style, string digits,
			logic [NUM_W-1:0] value, size_form_t form, term_fault_t fault);
		logic [NUM_W-1:0] eff;
		logic [7:0] a;
		logic [7:0] b;
		put_name(style, digits);
		put_bytes(32);
		eff = put_size(value, form);
		a = CH_GRAVE;
		b = CH_LF;
		if (fault == TERM_BAD_A) a = a ^ 8'($urandom_range(1, 255));
		if (fault == TERM_BAD_B) b = b ^ 8'($urandom_range(1, 255));
		archive_img.push_back(a);
		archive_img.push_back(b);
		return eff;
	endfunction

	task automatic run_directed();
		// Signature alone: an empty archive.
		archive_img.delete();
		put_magic(-1);
		send_image();
		// Signature wrong in its first byte, then in its last byte.
		archive_img.delete();
		put_magic(0);
		put_bytes(3);
		send_image();
		archive_img.delete();
		put_magic(7);
		put_bytes(2);
		send_image();
		// Archive ending inside the signature.
		archive_img.delete();
		put_magic(-1);
		repeat (3) void'(archive_img.pop_back());
		send_image();
		// One member of every kind; the final header with no data closes the archive.
		archive_img.delete();
		put_magic(-1);
		void'(put_header(NM_SYMTAB, "", 4, SZ_PLAIN, TERM_OK));
		put_bytes(4);
		void'(put_header(NM_NAMETAB, "", 7, SZ_LEADING, TERM_OK));
		put_bytes(7);
		put_pad(1);
		void'(put_header(NM_LONG, "3", 0, SZ_PLAIN, TERM_OK));
		void'(put_header(NM_LONG, "12x7", 0, SZ_PLAIN, TERM_OK));
		void'(put_header(NM_LONG, "999999999999999", 1, SZ_PLAIN, TERM_OK));
		put_bytes(1);
		put_pad(2);
		void'(put_header(NM_SLASH_WORD, "", 0, SZ_EMPTY, TERM_OK));
		void'(put_header(NM_SHORT, "", 10, SZ_JUNK, TERM_OK));
		put_bytes(10);
		void'(put_header(NM_PLAIN, "", 0, SZ_PLAIN, TERM_OK));
		send_image();
		// Long names before any table, against the first table and past a second one.
		archive_img.delete();
		put_magic(-1);
		void'(put_header(NM_LONG, "0", 0, SZ_PLAIN, TERM_OK));
		void'(put_header(NM_NAMETAB, "", 3, SZ_PLAIN, TERM_OK));
		put_bytes(3);
		put_pad(1);
		void'(put_header(NM_LONG, "2", 0, SZ_PLAIN, TERM_OK));
		void'(put_header(NM_LONG, "3", 0, SZ_PLAIN, TERM_OK));
		void'(put_header(NM_NAMETAB, "", 40, SZ_PLAIN, TERM_OK));
		put_bytes(40);
		void'(put_header(NM_LONG, "10", 0, SZ_PLAIN, TERM_OK));
		void'(put_header(NM_LONG, "2", 2, SZ_PLAIN, TERM_OK));
		put_bytes(2);
		send_image();
		// A newline straight after the signature is the first name byte; data then cut short.
		archive_img.delete();
		put_magic(-1);
		void'(put_header(NM_PLAIN, "", 5, SZ_PLAIN, TERM_OK));
		archive_img[8] = CH_LF;
		put_bytes(3);
		send_image();
		// Corrupt terminator, first byte and then second byte.
		archive_img.delete();
		put_magic(-1);
		void'(put_header(NM_SHORT, "", 0, SZ_PLAIN, TERM_BAD_A));
		put_bytes(4);
		send_image();
		archive_img.delete();
		put_magic(-1);
		void'(put_header(NM_SHORT, "", 0, SZ_PLAIN, TERM_BAD_B));
		put_bytes(1);
		send_image();
		// Archive ending inside a header, and right after a header that announces data.
		archive_img.delete();
		put_magic(-1);
		void'(put_header(NM_SHORT, "", 0, SZ_PLAIN, TERM_OK));
		repeat (30) void'(archive_img.pop_back());
		send_image();
		archive_img.delete();
		put_magic(-1);
		void'(put_header(NM_SHORT, "", 34'd9999999999, SZ_PLAIN, TERM_OK));
		send_image();
	endtask

	task automatic random_archive();
		int members;
		int k;
		int r;
		int cut;
		name_style_t style;
		size_form_t form;
		term_fault_t fault;
		logic [NUM_W-1:0] sz;
		logic [NUM_W-1:0] eff;
		longint unsigned big;
		string digits;
		bit huge;
		archive_img.delete();
		quiet = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 19) == 0) begin
			put_bytes($urandom_range(1, 80));
		end else begin
			put_magic(($urandom_range(0, 11) == 0) ? $urandom_range(0, 7) : -1);
			members = $urandom_range(1, 5);
			for (k = 0; k < members; k++) begin
				r = $urandom_range(0, 99);
				style = r < 10 ? NM_SYMTAB : r < 25 ? NM_NAMETAB : r < 50 ? NM_LONG :
					r < 75 ? NM_SHORT : r < 85 ? NM_PLAIN : r < 92 ? NM_SLASH_WORD : NM_RANDOM;
				r = $urandom_range(0, 9);
				digits = r == 0 ? "999999999999999" : r == 1 ? $sformatf("%0d", $urandom) :
					$sformatf("%0d", $urandom_range(0, 40));
				r = $urandom_range(0, 99);
				huge = (r >= 95);
				big = {$urandom, $urandom};
				big = big % 64'd9999999999 + 1;
				sz = r < 85 ? NUM_W'($urandom_range(0, 16)) :
					r < 95 ? NUM_W'($urandom_range(17, 200)) : big[NUM_W-1:0];
				r = $urandom_range(0, 9);
				form = r < 6 ? SZ_PLAIN : r < 8 ? SZ_LEADING : r < 9 ? SZ_JUNK : SZ_EMPTY;
				r = $urandom_range(0, 39);
				fault = r == 0 ? TERM_BAD_A : r == 1 ? TERM_BAD_B : TERM_OK;
				eff = put_header(style, digits, sz, form, fault);
				// A member this large never fits, so the archive stops inside its data.
				if (huge && eff != 0) begin
					put_bytes($urandom_range(0, 5));
					break;
				end
				put_bytes(32'(eff));
				put_pad($urandom_range(0, 2));
			end
			if ($urandom_range(0, 6) == 0) begin
				cut = $urandom_range(1, archive_img.size());
				while (archive_img.size() > cut) void'(archive_img.pop_back());
			end
		end
		send_image();
	endtask

	initial begin : stimulus
		bit paused;
		paused = 1'b0;
		wait (arst_n);
		@(posedge clk);
		run_directed();
		drain();
		while (sent_bytes < MIN_BYTES) begin
			random_archive();
			if (!paused && sent_bytes >= MIN_BYTES / 2) begin
				drain();
				paused = 1'b1;
			end
		end
		s_tvalid <= 1'b0;
		// Let the final accepted byte be noted before the owed results are counted.
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("ar_archive_header_parser verification clean");
		else
			$display("ar_archive_header_parser verification failed");
		$finish;
	end

endmodule
